// ----- rtl/core/slrv_pkg.sv -----
// Package for sort_and_list_repeated_values: store geometry, field widths
// and the control state type. No dependencies.
package slrv_pkg;
   localparam int MAX_ELEMENTS = 64;
   localparam int RESULT_LIMIT = 32;
   localparam int VALUE_W      = 16;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int RES_W        = $clog2(RESULT_LIMIT + 1);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_START,
      ST_SORT_FIRST,
      ST_SORT_CMP,
      ST_SORT_TAIL,
      ST_SCAN_START,
      ST_SCAN_FIRST,
      ST_SCAN_CMP,
      ST_SCAN_END
   } state_type;
endpackage

// ----- rtl/core/sort_and_list_repeated_values.sv -----
// Top level of sort_and_list_repeated_values: loads a set of signed values,
// bubble sorts them in place and lists each repeated value once.
// Depends on slrv_pkg and slrv_ram.
//
// Items are taken one per cycle until the one with tlast closes the set;
// items past the 64-entry store are dropped. The set of n elements is then
// sorted in the store RAM, one compare-and-write per cycle through its one
// read port and one write port. At most n - 1 passes run (fewer when a pass
// makes no swap). The scan can stall while the result side holds back. No
// new item is accepted from the closing item until the final result is
// registered; that result may still wait on rsp_tready while the next set
// loads.
module sort_and_list_repeated_values
   import slrv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] repeated_value
   output logic        rsp_tuser,   // [0] found
   output logic        rsp_tlast
);
   state_type state_ff, state_in;

   logic [CNT_W-1:0]   cnt_ff, cnt_in, cnt_after;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0]  pass_end_ff, pass_end_in;
   logic [ADDR_W-1:0]  last_idx;
   logic               swapped_ff, swapped_in;
   logic [VALUE_W-1:0] carry_ff, carry_in;
   logic [VALUE_W-1:0] prev_ff, prev_in;
   logic [VALUE_W-1:0] pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               in_run_ff, in_run_in;
   logic [RES_W-1:0]   produced_ff, produced_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               ram_we, ram_re;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [VALUE_W-1:0] ram_wdata, ram_rdata;

   logic req_fire, out_free, store_full, scan_new, scan_stall;

   slrv_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(MAX_ELEMENTS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign store_full = (cnt_ff == CNT_W'(MAX_ELEMENTS));
   assign cnt_after  = store_full ? cnt_ff : cnt_ff + CNT_W'(1);
   assign last_idx   = ADDR_W'(cnt_ff - CNT_W'(1));
   assign scan_new   = (ram_rdata == prev_ff) && !in_run_ff &&
                       (produced_ff < RES_W'(RESULT_LIMIT));
   assign scan_stall = scan_new && pend_valid_ff && !out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_tlast) begin
               state_in = (cnt_after > CNT_W'(1)) ? ST_SORT_START : ST_SCAN_START;
            end
         end
         ST_SORT_START: state_in = ST_SORT_FIRST;
         ST_SORT_FIRST: state_in = ST_SORT_CMP;
         ST_SORT_CMP: begin
            if (idx_ff + ADDR_W'(1) == pass_end_ff) begin
               state_in = ST_SORT_TAIL;
            end
         end
         ST_SORT_TAIL: begin
            state_in = (swapped_ff && pass_end_ff > ADDR_W'(1)) ? ST_SORT_START
                                                                : ST_SCAN_START;
         end
         ST_SCAN_START: state_in = ST_SCAN_FIRST;
         ST_SCAN_FIRST: state_in = (cnt_ff == CNT_W'(1)) ? ST_SCAN_END : ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (!scan_stall && idx_ff == last_idx) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            if (out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pass_end_in   = pass_end_ff;
      swapped_in    = swapped_ff;
      carry_in      = carry_ff;
      prev_in       = prev_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      in_run_in     = in_run_ff;
      produced_in   = produced_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = carry_ff;
      ram_re        = 1'b0;
      ram_raddr     = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               ram_we    = !store_full;
               ram_waddr = cnt_ff[ADDR_W-1:0];
               ram_wdata = req_tdata;
               cnt_in    = cnt_after;
               if (req_tlast) begin
                  pass_end_in = ADDR_W'(cnt_after - CNT_W'(1));
               end
            end
         end
         ST_SORT_START: begin
            ram_re     = 1'b1;
            swapped_in = 1'b0;
         end
         ST_SORT_FIRST: begin
            carry_in  = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(1);
            idx_in    = '0;
         end
         ST_SORT_CMP: begin
            ram_we = 1'b1;
            if ($signed(carry_ff) > $signed(ram_rdata)) begin
               ram_wdata  = ram_rdata;
               swapped_in = 1'b1;
            end else begin
               carry_in = ram_rdata;
            end
            idx_in = idx_ff + ADDR_W'(1);
            if (idx_ff + ADDR_W'(1) != pass_end_ff) begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff + ADDR_W'(2);
            end
         end
         ST_SORT_TAIL: begin
            ram_we    = 1'b1;
            ram_waddr = pass_end_ff;
            if (swapped_ff && pass_end_ff > ADDR_W'(1)) begin
               pass_end_in = pass_end_ff - ADDR_W'(1);
            end
         end
         ST_SCAN_START: begin
            ram_re        = 1'b1;
            in_run_in     = 1'b0;
            pend_valid_in = 1'b0;
            produced_in   = '0;
         end
         ST_SCAN_FIRST: begin
            prev_in   = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(1);
            idx_in    = ADDR_W'(1);
         end
         ST_SCAN_CMP: begin
            if (!scan_stall) begin
               if (scan_new) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pend_ff;
                     rsp_found_in = 1'b1;
                     rsp_last_in  = 1'b0;
                  end
                  pend_in       = ram_rdata;
                  pend_valid_in = 1'b1;
                  produced_in   = produced_ff + RES_W'(1);
               end
               in_run_in = (ram_rdata == prev_ff);
               prev_in   = ram_rdata;
               if (idx_ff != last_idx) begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff + ADDR_W'(1);
                  idx_in    = idx_ff + ADDR_W'(1);
               end
            end
         end
         ST_SCAN_END: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = pend_valid_ff ? pend_ff : '0;
               rsp_found_in  = pend_valid_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               cnt_in        = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         swapped_ff    <= 1'b0;
         in_run_ff     <= 1'b0;
         produced_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         swapped_ff    <= swapped_in;
         in_run_ff     <= in_run_in;
         produced_ff   <= produced_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pass_end_ff  <= pass_end_in;
      carry_ff     <= carry_in;
      prev_ff      <= prev_in;
      pend_ff      <= pend_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ELEMENTS))
      else $error("element count beyond store depth");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("read and write to the same store entry");

   a_cmp_in_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT_CMP) |-> (idx_ff < pass_end_ff))
      else $error("compare index past end of pass");

   a_set_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_END && out_free) |=> (cnt_ff == '0 && rsp_tlast && rsp_tvalid))
      else $error("set not closed by final item");
endmodule

// ----- rtl/core/slrv_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. No dependencies.
module slrv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
